// File: sv/kmp_sm_pkg.sv
// Shared types and constants for the streaming KMP matcher.
// Used by kmp_sm_tables, kmp_stream_matcher_unit and kmp_sm_checker; no dependencies.
package kmp_sm_pkg;

    localparam int unsigned MAX_PATTERN = 16;
    localparam int unsigned PAT_AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int unsigned LEN_W  = $clog2(MAX_PATTERN + 1);

    localparam logic CMD_PATTERN = 1'b0;
    localparam logic CMD_TEXT    = 1'b1;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FULL = 1'b1;

    typedef logic [PAT_AW-1:0] t_pidx;
    typedef logic [LEN_W-1:0]  t_len;

    typedef enum logic {
        S_IDLE,
        S_WALK
    } t_state;

    // write request into the pattern store and failure table
    typedef struct packed {
        logic        pat_we;
        logic        fail_we;
        t_pidx       idx;
        logic [7:0]  pat_byte;
        t_pidx       fail_val;
    } t_tbl_wr;

endpackage

// File: sv/kmp_sm_tables.sv
// Pattern store and failure table: small register files with one write request
// and one read address each, read data registered. Depends on kmp_sm_pkg.
module kmp_sm_tables (
    input  logic               i_clk,
    input  kmp_sm_pkg::t_tbl_wr i_wr,
    input  kmp_sm_pkg::t_pidx  i_pat_addr,
    input  kmp_sm_pkg::t_pidx  i_fail_addr,
    output logic [7:0]         o_pat_byte,
    output kmp_sm_pkg::t_pidx  o_fail_val
);
    import kmp_sm_pkg::*;

    logic [7:0] r_pat  [MAX_PATTERN];
    t_pidx      r_fail [MAX_PATTERN];
    logic [7:0] r_pat_rd;
    t_pidx      r_fail_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr.pat_we) begin
            r_pat[i_wr.idx] <= i_wr.pat_byte;
        end
        if (i_wr.fail_we) begin
            r_fail[i_wr.idx] <= i_wr.fail_val;
        end
        r_pat_rd  <= r_pat[i_pat_addr];
        r_fail_rd <= r_fail[i_fail_addr];
    end

    assign o_pat_byte = r_pat_rd;
    assign o_fail_val = r_fail_rd;

endmodule

// File: sv/kmp_stream_matcher_unit.sv
// Streaming KMP matcher top level: request sequencer, failure-link walk, result register.
// Depends on kmp_sm_pkg and kmp_sm_tables.
// A pattern byte into an empty pattern, a dropped byte, or a text byte with an empty
// pattern is answered from S_IDLE; other requests walk f failure links (0..15) in S_WALK.
// A new request is accepted only in S_IDLE with no stalled result pending; the single
// compare unit is shared by the walk. Reset (synchronous, active low) clears lengths,
// position, state and the result valid; the pattern store and failure table are not cleared.
module kmp_stream_matcher_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [7:0]  i_data_byte,
    input  logic        i_restart,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_match_found,
    output logic [31:0] o_match_start,
    output logic [31:0] o_match_end,
    output logic        o_status
);
    import kmp_sm_pkg::*;

    t_state      r_state, n_state;
    logic        r_cmd, n_cmd;
    logic [7:0]  r_byte, n_byte;
    t_len        r_len, n_len;
    t_pidx       r_bpl, n_bpl;
    t_len        r_matched, n_matched;
    t_len        r_k, n_k;
    logic [31:0] r_pos, n_pos;

    logic        r_out_valid, n_out_valid;
    logic        r_found, n_found;
    logic [31:0] r_start, n_start;
    logic [31:0] r_end, n_end;
    logic        r_status, n_status;

    t_tbl_wr     w_wr;
    t_pidx       w_fail_addr;
    logic [7:0]  w_pat_byte;
    t_pidx       w_fail_val;
    logic        w_eq;
    logic        w_step;
    t_len        w_j;
    logic        w_accept;
    t_len        w_eff_len;
    t_len        w_eff_matched;
    logic [31:0] w_eff_pos;

    // address the tables with the next k so the read data lines up with r_k
    kmp_sm_tables u_tables (
        .i_clk       (i_clk),
        .i_wr        (w_wr),
        .i_pat_addr  (n_k[PAT_AW-1:0]),
        .i_fail_addr (w_fail_addr),
        .o_pat_byte  (w_pat_byte),
        .o_fail_val  (w_fail_val)
    );

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;

    // shared compare: one failure-link step per cycle
    assign w_eq   = (w_pat_byte == r_byte);
    assign w_step = (r_k != '0) && !w_eq;
    assign w_j    = r_k + t_len'(w_eq);
    assign w_fail_addr = t_pidx'(n_k - t_len'(1));

    assign w_eff_len     = (i_restart && (i_cmd == CMD_PATTERN)) ? '0 : r_len;
    assign w_eff_matched = i_restart ? '0 : r_matched;
    assign w_eff_pos     = i_restart ? '0 : r_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_bpl       <= '0;
            r_matched   <= '0;
            r_k         <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_bpl       <= n_bpl;
            r_matched   <= n_matched;
            r_k         <= n_k;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_byte   <= n_byte;
        r_found  <= n_found;
        r_start  <= n_start;
        r_end    <= n_end;
        r_status <= n_status;
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_byte      = r_byte;
        n_len       = r_len;
        n_bpl       = r_bpl;
        n_matched   = r_matched;
        n_k         = r_k;
        n_pos       = r_pos;
        n_out_valid = r_out_valid && !i_out_ready;
        n_found     = r_found;
        n_start     = r_start;
        n_end       = r_end;
        n_status    = r_status;
        w_wr        = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd    = i_cmd;
                    n_byte   = i_data_byte;
                    n_found  = 1'b0;
                    n_start  = '0;
                    n_end    = '0;
                    n_status = ST_OK;
                    if (i_cmd == CMD_PATTERN) begin
                        if (i_restart) begin
                            n_len     = '0;
                            n_bpl     = '0;
                            n_matched = '0;
                        end
                        if (w_eff_len >= t_len'(MAX_PATTERN)) begin
                            // drop the byte
                            n_status    = ST_FULL;
                            n_out_valid = 1'b1;
                        end else begin
                            w_wr.pat_we   = 1'b1;
                            w_wr.idx      = w_eff_len[PAT_AW-1:0];
                            w_wr.pat_byte = i_data_byte;
                            if (w_eff_len == '0) begin
                                w_wr.fail_we  = 1'b1;
                                w_wr.fail_val = '0;
                                n_bpl         = '0;
                                n_len         = t_len'(1);
                                n_out_valid   = 1'b1;
                            end else begin
                                n_k     = t_len'(r_bpl);
                                n_state = S_WALK;
                            end
                        end
                    end else begin
                        n_matched = w_eff_matched;
                        if (r_len == '0) begin
                            n_pos       = w_eff_pos + 32'd1;
                            n_out_valid = 1'b1;
                        end else begin
                            n_pos   = w_eff_pos;
                            n_k     = w_eff_matched;
                            n_state = S_WALK;
                        end
                    end
                end
            end
            S_WALK: begin
                if (w_step) begin
                    n_k = t_len'(w_fail_val);
                end else begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    if (r_cmd == CMD_PATTERN) begin
                        w_wr.fail_we  = 1'b1;
                        w_wr.idx      = r_len[PAT_AW-1:0];
                        w_wr.fail_val = t_pidx'(w_j);
                        n_bpl         = t_pidx'(w_j);
                        n_len         = r_len + t_len'(1);
                    end else begin
                        if (w_j == r_len) begin
                            n_found   = 1'b1;
                            n_end     = r_pos;
                            n_start   = r_pos - (32'(r_len) - 32'd1);
                            // follow the link so overlapping matches are found;
                            // r_bpl holds the link of the final pattern byte
                            n_matched = t_len'(r_bpl);
                        end else begin
                            n_matched = w_j;
                        end
                        n_pos = r_pos + 32'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid   = r_out_valid;
    assign o_match_found = r_found;
    assign o_match_start = r_start;
    assign o_match_end   = r_end;
    assign o_status      = r_status;

endmodule

// File: sv/kmp_sm_checker.sv
// Port-level checks for kmp_stream_matcher_unit, attached by the bind below.
// Depends on kmp_sm_pkg.
module kmp_sm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_match_found,
    input logic [31:0] o_match_start,
    input logic [31:0] o_match_end,
    input logic        o_status
);
    import kmp_sm_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_match_found)
            && $stable(o_match_start) && $stable(o_match_end) && $stable(o_status))
        else $error("result changed while stalled");

    // an occurrence spans at most the pattern capacity and reports status OK
    a_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_match_found |->
            (o_match_end - o_match_start) < 32'(MAX_PATTERN) && o_status == ST_OK)
        else $error("bad match span or status");

    // no match means zero positions
    a_nomatch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_match_found |-> o_match_start == '0 && o_match_end == '0)
        else $error("positions set without a match");

    // reset clears the result valid
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind kmp_stream_matcher_unit kmp_sm_checker u_kmp_sm_checker (.*);
